FILE: rtl/mtt_pkg.sv
// Shared types, character codes and decode functions of the map text tokenizer.
package mtt_pkg;

  // Token kinds on the result channel
  localparam logic [3:0] KIND_LBRACE = 4'd0;
  localparam logic [3:0] KIND_RBRACE = 4'd1;
  localparam logic [3:0] KIND_LPAREN = 4'd2;
  localparam logic [3:0] KIND_RPAREN = 4'd3;
  localparam logic [3:0] KIND_LBRACK = 4'd4;
  localparam logic [3:0] KIND_RBRACK = 4'd5;
  localparam logic [3:0] KIND_STRING = 4'd6;
  localparam logic [3:0] KIND_WORD   = 4'd7;
  localparam logic [3:0] KIND_END    = 4'd8;

  // Bracket code returned when a byte is not one of the six bracket characters
  localparam logic [2:0] BK_NONE = 3'd6;

  // Lexer modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_SLASH   = 3'd1;
  localparam logic [2:0] MODE_COMMENT = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_WORD    = 3'd4;

  // Character codes
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } mtt_in_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic       has_char;
    logic [7:0] char_out;
    logic       token_done;
    logic       last_of_run;
  } mtt_res_t;

  // All results caused by one input item, in emission order
  typedef struct packed {
    logic [1:0]         cnt;
    mtt_res_t [2:0]     res;
  } mtt_burst_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic [2:0] bracket_kind(input logic [7:0] c);
    logic [2:0] bk;
    case (c)
      CH_LBRACE: bk = KIND_LBRACE[2:0];
      CH_RBRACE: bk = KIND_RBRACE[2:0];
      CH_LPAREN: bk = KIND_LPAREN[2:0];
      CH_RPAREN: bk = KIND_RPAREN[2:0];
      CH_LBRACK: bk = KIND_LBRACK[2:0];
      CH_RBRACK: bk = KIND_RBRACK[2:0];
      default:   bk = BK_NONE;
    endcase
    return bk;
  endfunction

  function automatic mtt_res_t mk_res(input logic [3:0] kind, input logic has_char,
                                      input logic [7:0] ch, input logic done);
    mtt_res_t r;
    r.token_kind  = kind;
    r.has_char    = has_char;
    r.char_out    = has_char ? ch : 8'd0;
    r.token_done  = done;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/mtt_lex.sv
// Lexer mode register and single-pass byte decode into a burst of up to three results.
module mtt_lex (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  mtt_pkg::mtt_in_t   in_item,
  output mtt_pkg::mtt_burst_t burst
);
  import mtt_pkg::*;

  logic [2:0] mode_r;
  logic [2:0] mode_nxt;

  always_comb begin
    logic [7:0]  c;
    logic [2:0]  bk;
    logic        sp;
    logic [1:0]  cnt;
    logic [1:0]  cnt_m1;
    mtt_res_t [2:0] res;
    c        = in_item.text_byte;
    bk       = bracket_kind(c);
    sp       = is_space(c);
    cnt      = 2'd0;
    res      = '0;
    mode_nxt = mode_r;
    if (in_item.end_of_text) begin
      unique case (mode_r)
        MODE_SLASH: begin
          res[0] = mk_res(KIND_WORD, 1'b1, CH_SLASH, 1'b0);
          res[1] = mk_res(KIND_WORD, 1'b0, 8'd0, 1'b1);
          res[2] = mk_res(KIND_END, 1'b0, 8'd0, 1'b1);
          cnt    = 2'd3;
        end
        MODE_STRING: begin
          res[0] = mk_res(KIND_STRING, 1'b0, 8'd0, 1'b1);
          res[1] = mk_res(KIND_END, 1'b0, 8'd0, 1'b1);
          cnt    = 2'd2;
        end
        MODE_WORD: begin
          res[0] = mk_res(KIND_WORD, 1'b0, 8'd0, 1'b1);
          res[1] = mk_res(KIND_END, 1'b0, 8'd0, 1'b1);
          cnt    = 2'd2;
        end
        default: begin
          res[0] = mk_res(KIND_END, 1'b0, 8'd0, 1'b1);
          cnt    = 2'd1;
        end
      endcase
      mode_nxt = MODE_IDLE;
    end else begin
      unique case (mode_r)
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            mode_nxt = MODE_COMMENT;
          end else begin
            // Lone slash opens a word; the held slash leads the burst
            res[0] = mk_res(KIND_WORD, 1'b1, CH_SLASH, 1'b0);
            if (sp) begin
              res[1]   = mk_res(KIND_WORD, 1'b0, 8'd0, 1'b1);
              cnt      = 2'd2;
              mode_nxt = MODE_IDLE;
            end else if (bk != BK_NONE) begin
              res[1]   = mk_res(KIND_WORD, 1'b0, 8'd0, 1'b1);
              res[2]   = mk_res({1'b0, bk}, 1'b0, 8'd0, 1'b1);
              cnt      = 2'd3;
              mode_nxt = MODE_IDLE;
            end else begin
              res[1]   = mk_res(KIND_WORD, 1'b1, c, 1'b0);
              cnt      = 2'd2;
              mode_nxt = MODE_WORD;
            end
          end
        end
        MODE_COMMENT: begin
          if (c == CH_LF) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            res[0]   = mk_res(KIND_STRING, 1'b0, 8'd0, 1'b1);
            mode_nxt = MODE_IDLE;
          end else begin
            res[0] = mk_res(KIND_STRING, 1'b1, c, 1'b0);
          end
          cnt = 2'd1;
        end
        MODE_WORD: begin
          if (sp) begin
            res[0]   = mk_res(KIND_WORD, 1'b0, 8'd0, 1'b1);
            cnt      = 2'd1;
            mode_nxt = MODE_IDLE;
          end else if (bk != BK_NONE) begin
            res[0]   = mk_res(KIND_WORD, 1'b0, 8'd0, 1'b1);
            res[1]   = mk_res({1'b0, bk}, 1'b0, 8'd0, 1'b1);
            cnt      = 2'd2;
            mode_nxt = MODE_IDLE;
          end else begin
            res[0] = mk_res(KIND_WORD, 1'b1, c, 1'b0);
            cnt    = 2'd1;
          end
        end
        default: begin
          // Between tokens; unused codes act the same
          mode_nxt = MODE_IDLE;
          if (c == CH_SLASH) begin
            mode_nxt = MODE_SLASH;
          end else if (sp) begin
            mode_nxt = MODE_IDLE;
          end else if (bk != BK_NONE) begin
            res[0] = mk_res({1'b0, bk}, 1'b0, 8'd0, 1'b1);
            cnt    = 2'd1;
          end else if (c == CH_QUOTE) begin
            mode_nxt = MODE_STRING;
          end else begin
            res[0]   = mk_res(KIND_WORD, 1'b1, c, 1'b0);
            cnt      = 2'd1;
            mode_nxt = MODE_WORD;
          end
        end
      endcase
    end
    cnt_m1 = cnt - 2'd1;
    for (int i = 0; i < 3; i++) begin
      res[i].last_of_run = (cnt != 2'd0) && (cnt_m1 == 2'(i));
    end
    burst.cnt = cnt;
    burst.res = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

`ifndef SYNTHESIS
  a_eot_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.end_of_text |=> mode_r == MODE_IDLE)
    else $error("mode not idle after end of text");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_IDLE || mode_r == MODE_SLASH || mode_r == MODE_COMMENT ||
    mode_r == MODE_STRING || mode_r == MODE_WORD)
    else $error("unused mode code entered");

  a_lone_slash: assert property (@(posedge clk) disable iff (!rst_n)
    accept && mode_r == MODE_SLASH && !in_item.end_of_text &&
    in_item.text_byte != CH_SLASH |-> burst.cnt >= 2'd2 && burst.res[0].has_char)
    else $error("held slash not emitted");
`endif

endmodule

FILE: rtl/mtt_obuf.sv
// Result buffer: holds one item's burst and presents it one result per transfer.
module mtt_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  mtt_pkg::mtt_burst_t burst,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output mtt_pkg::mtt_res_t   out_data
);
  import mtt_pkg::*;

  mtt_res_t [2:0] slot_r;
  logic [1:0]     left_r;
  logic           pop;

  assign out_valid = (left_r != 2'd0);
  assign out_data  = slot_r[0];
  assign pop       = out_valid && out_ready;
  // Take a new burst when empty or once the last held result leaves in this cycle
  assign can_load  = (left_r == 2'd0) || ((left_r == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 2'd0;
    end else if (load) begin
      left_r <= burst.cnt;
    end else if (pop) begin
      left_r <= left_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= burst.res;
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

`ifndef SYNTHESIS
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load && burst.cnt != 2'd0 |=> out_valid)
    else $error("loaded burst not presented");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop && left_r == 2'd1 && !load |=> !out_valid)
    else $error("result repeated after drain");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_of_run == (left_r == 2'd1))
    else $error("last_of_run misplaced");
`endif

endmodule

FILE: rtl/map_text_tokenizer.sv
// Top level of the map text tokenizer: byte in, token results out.
// Latency: a byte's first result is valid the cycle after its transfer.
// Throughput: one byte per cycle while out_ready is high and each byte gives
//   at most one result; else the next byte waits for the last of up to three.
// Reset (rst_n low, synchronous): lexer returns to idle, result buffer empties.
module map_text_tokenizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mtt_pkg::mtt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mtt_pkg::mtt_res_t out_data
);
  import mtt_pkg::*;

  mtt_burst_t burst;
  logic       in_xfer;

  // A byte transfers whenever the buffer can take its whole burst; bytes
  // that give no result (whitespace, comment text, opening quote) still
  // advance the lexer mode and load an empty burst, leaving the buffer empty.
  assign in_xfer = in_valid && in_ready;

  // Decode the byte against the current mode and advance the mode
  mtt_lex u_lex (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_xfer),
    .in_item (in_data),
    .burst   (burst)
  );

  // Hold the burst and hand out one result per transfer
  mtt_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_xfer),
    .burst     (burst),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
